FILE: rtl/core/tlbclk_pkg.sv
// shared types and constants for the clock-replacement tlb
package tlbclk_pkg;

  localparam int TLB_DEPTH = 16;
  localparam int VPN_BITS  = 20;
  localparam int PFN_BITS  = 20;
  localparam int PID_BITS  = 8;
  localparam int CFG_W     = 5;
  localparam int IDX_W     = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam int LIM_W     = (CFG_W > IDX_W + 1) ? CFG_W : IDX_W + 1;

  localparam int IN_W        = VPN_BITS + 1 + PID_BITS + PFN_BITS;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = 1 + PFN_BITS + 1;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic [VPN_BITS-1:0] page;
    logic [PID_BITS-1:0] owner;
    logic [PFN_BITS-1:0] frame;
  } tlb_entry_t;

  typedef struct packed {
    logic [PFN_BITS-1:0] table_pfn;
    logic [PID_BITS-1:0] process_id;
    logic                is_write;
    logic [VPN_BITS-1:0] vpn;
  } req_t;

  typedef struct packed {
    logic                mark_page_dirty;
    logic [PFN_BITS-1:0] frame;
    logic                hit;
  } res_t;

  typedef struct packed {
    logic       wr_en;
    idx_t       wr_idx;
    tlb_entry_t wr_entry;
    logic       clr_en;
    idx_t       clr_idx;
    idx_t       rd_idx;
  } store_ctl_t;

  typedef struct packed {
    tlb_entry_t             rd_entry;
    logic [TLB_DEPTH-1:0]   valid;
    logic [TLB_DEPTH-1:0]   used;
  } store_sts_t;

endpackage

FILE: rtl/core/tlbclk_store.sv
// entry storage with valid and used bits, one read index, one write index and a used-bit clear index
module tlbclk_store (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tlbclk_pkg::store_ctl_t ctl,
  output tlbclk_pkg::store_sts_t sts
);

  tlbclk_pkg::tlb_entry_t               entry_r [tlbclk_pkg::TLB_DEPTH];
  logic [tlbclk_pkg::TLB_DEPTH-1:0]     valid_r;
  logic [tlbclk_pkg::TLB_DEPTH-1:0]     used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      used_r  <= '0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[ctl.wr_idx] <= 1'b1;
        used_r[ctl.wr_idx]  <= 1'b1;
      end
      if (ctl.clr_en) begin
        used_r[ctl.clr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      entry_r[ctl.wr_idx] <= ctl.wr_entry;
    end
  end

  assign sts.rd_entry = entry_r[ctl.rd_idx];
  assign sts.valid    = valid_r;
  assign sts.used     = used_r;

endmodule

FILE: rtl/core/tlbclk_seq.sv
// lookup sequencer: one shared entry compare, clock hand sweep and fill
module tlbclk_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  tlbclk_pkg::req_t              req,
  input  logic [tlbclk_pkg::CFG_W-1:0]  cfg_entries,
  output tlbclk_pkg::store_ctl_t        ctl,
  input  tlbclk_pkg::store_sts_t        sts,
  output logic                          res_valid,
  input  logic                          res_ready,
  output tlbclk_pkg::res_t              res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWEEP,
    ST_RESP
  } state_t;

  state_t                    state_r, state_nxt;
  tlbclk_pkg::idx_t          idx_r, idx_nxt;
  tlbclk_pkg::idx_t          last_r, last_nxt;
  tlbclk_pkg::idx_t          hand_r, hand_nxt;
  tlbclk_pkg::idx_t          inv_idx_r, inv_idx_nxt;
  logic                      inv_found_r, inv_found_nxt;
  tlbclk_pkg::req_t          req_r, req_nxt;
  tlbclk_pkg::res_t          pend_r, pend_nxt;
  tlbclk_pkg::res_t          res_r, res_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic [tlbclk_pkg::LIM_W-1:0] cfg_ext;
  tlbclk_pkg::idx_t          last_calc;
  tlbclk_pkg::idx_t          cand;
  tlbclk_pkg::idx_t          fill_slot;
  logic                      fill_go;
  logic                      match;
  logic                      inv_now;
  logic                      clr_en;
  tlbclk_pkg::idx_t          clr_idx;

  // active count: zero acts as one, saturates at depth
  always_comb begin
    cfg_ext = tlbclk_pkg::LIM_W'(cfg_entries);
    if (cfg_ext == '0) begin
      last_calc = '0;
    end else if (cfg_ext > tlbclk_pkg::LIM_W'(tlbclk_pkg::TLB_DEPTH)) begin
      last_calc = tlbclk_pkg::IDX_W'(tlbclk_pkg::TLB_DEPTH - 1);
    end else begin
      last_calc = tlbclk_pkg::IDX_W'(cfg_ext - 1'b1);
    end
  end

  assign match   = sts.valid[idx_r] && (sts.rd_entry.page == req_r.vpn)
                   && (sts.rd_entry.owner == req_r.process_id);
  assign inv_now = !sts.valid[idx_r];
  assign cand    = (hand_r >= last_r) ? '0 : hand_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    hand_nxt      = hand_r;
    inv_idx_nxt   = inv_idx_r;
    inv_found_nxt = inv_found_r;
    req_nxt       = req_r;
    pend_nxt      = pend_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !res_ready;
    fill_go       = 1'b0;
    fill_slot     = cand;
    clr_en        = 1'b0;
    clr_idx       = cand;

    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          req_nxt       = req;
          last_nxt      = last_calc;
          idx_nxt       = '0;
          inv_found_nxt = 1'b0;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (match) begin
          pend_nxt.hit             = 1'b1;
          pend_nxt.frame           = sts.rd_entry.frame;
          pend_nxt.mark_page_dirty = 1'b0;
          state_nxt                = ST_RESP;
        end else begin
          if (inv_now && !inv_found_r) begin
            inv_found_nxt = 1'b1;
            inv_idx_nxt   = idx_r;
          end
          if (idx_r == last_r) begin
            if (inv_found_r || inv_now) begin
              fill_go   = 1'b1;
              fill_slot = inv_found_r ? inv_idx_r : idx_r;
            end else begin
              state_nxt = ST_SWEEP;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_SWEEP: begin
        if (!sts.used[cand]) begin
          fill_go   = 1'b1;
          fill_slot = cand;
        end else begin
          clr_en   = 1'b1;
          hand_nxt = cand;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || res_ready) begin
          res_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fill_go) begin
      hand_nxt                 = fill_slot;
      pend_nxt.hit             = 1'b0;
      pend_nxt.frame           = req_r.table_pfn;
      pend_nxt.mark_page_dirty = req_r.is_write;
      state_nxt                = ST_RESP;
    end
  end

  assign ctl.wr_en          = fill_go;
  assign ctl.wr_idx         = fill_slot;
  assign ctl.wr_entry.page  = req_r.vpn;
  assign ctl.wr_entry.owner = req_r.process_id;
  assign ctl.wr_entry.frame = req_r.table_pfn;
  assign ctl.clr_en         = clr_en;
  assign ctl.clr_idx        = clr_idx;
  assign ctl.rd_idx         = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      last_r      <= '0;
      hand_r      <= '0;
      inv_idx_r   <= '0;
      inv_found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      last_r      <= last_nxt;
      hand_r      <= hand_nxt;
      inv_idx_r   <= inv_idx_nxt;
      inv_found_r <= inv_found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r  <= req_nxt;
    pend_r <= pend_nxt;
    res_r  <= res_nxt;
  end

  assign req_ready = (state_r == ST_IDLE);
  assign res_valid = out_valid_r;
  assign res       = res_r;

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= last_r))
    else $error("scan index beyond active entries");

  a_miss_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && !pend_r.hit) |-> (sts.valid[hand_r] && sts.used[hand_r]))
    else $error("filled entry not valid and used");

  a_hand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && !pend_r.hit) |-> (hand_r <= last_r))
    else $error("clock hand outside active entries");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid && req_ready) |=> (state_r == ST_SCAN && idx_r == '0))
    else $error("accepted transaction did not start scan");

  a_sweep_has_no_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> !inv_found_r)
    else $error("sweep entered with an invalid entry available");

endmodule

FILE: rtl/core/tlb_lookup_clock_replace_core.sv
// top level of the fully associative tlb with clock replacement
// throughput: one transaction at a time; the single entry compare and the
//   hand sweep visit one entry per cycle, the result register frees the input
// reset (rst_n low, synchronous): all entries invalid and unused, hand at zero,
//   entries in use set to 16, no result pending
module tlb_lookup_clock_replace_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // vpn, is_write, process_id, table_pfn, zero pad
  input  logic [tlbclk_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // hit, frame, mark_page_dirty, zero pad
  output logic [tlbclk_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tlbclk_pkg::CFG_W-1:0]       cfg_data
);

  logic [tlbclk_pkg::CFG_W-1:0] entries_in_use_r;
  tlbclk_pkg::req_t             req;
  tlbclk_pkg::res_t             res;
  tlbclk_pkg::store_ctl_t       ctl;
  tlbclk_pkg::store_sts_t       sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= tlbclk_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entries_in_use_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  assign req = tlbclk_pkg::req_t'(in_tdata[tlbclk_pkg::IN_W-1:0]);

  tlbclk_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .sts   (sts)
  );

  tlbclk_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req         (req),
    .cfg_entries (entries_in_use_r),
    .ctl         (ctl),
    .sts         (sts),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res)
  );

  assign out_tdata = tlbclk_pkg::OUT_TDATA_W'(res);

endmodule

FILE: tb/tlb_lookup_clock_replace_core_tb.sv
// self-checking testbench for the clock-replacement tlb core
`timescale 1ns / 100ps

module tlb_lookup_clock_replace_core_tb;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_CYCLES  = 2 * tlbclk_pkg::TLB_DEPTH + 8;
  localparam int PHASE_ITEMS   = 110;
  localparam int REPORT_MAX    = 10;

  localparam logic [tlbclk_pkg::VPN_BITS-1:0] VPN_TOP = '1;
  localparam logic [tlbclk_pkg::PID_BITS-1:0] PID_TOP = '1;
  localparam logic [tlbclk_pkg::PFN_BITS-1:0] PFN_TOP = '1;

  typedef enum logic {ROW_XLAT, ROW_LIMIT} row_kind_t;

  typedef struct {
    row_kind_t                     kind;
    tlbclk_pkg::req_t              req;
    logic [tlbclk_pkg::CFG_W-1:0]  limit;
    bit                            typed;
    tlbclk_pkg::res_t              want;
  } dir_row_t;

  logic                               clk;
  logic                               rst_n      = 1'b0;
  logic                               in_tvalid  = 1'b0;
  logic                               in_tready;
  logic [tlbclk_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [tlbclk_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                               cfg_valid  = 1'b0;
  logic                               cfg_ready;
  logic [tlbclk_pkg::CFG_W-1:0]       cfg_data   = '0;

  // shadow copy of the translation buffer
  logic                               shadow_valid [tlbclk_pkg::TLB_DEPTH];
  logic                               shadow_used  [tlbclk_pkg::TLB_DEPTH];
  logic [tlbclk_pkg::VPN_BITS-1:0]    shadow_page  [tlbclk_pkg::TLB_DEPTH];
  logic [tlbclk_pkg::PFN_BITS-1:0]    shadow_frame [tlbclk_pkg::TLB_DEPTH];
  logic [tlbclk_pkg::PID_BITS-1:0]    shadow_owner [tlbclk_pkg::TLB_DEPTH];
  int                                 shadow_hand;
  logic [tlbclk_pkg::CFG_W-1:0]       shadow_limit;

  tlbclk_pkg::res_t                   xlat_pending [$];
  tlbclk_pkg::req_t                   recent_pairs [$];
  dir_row_t                           dir_rows     [$];
  int                                 mismatches;
  int                                 cycles;

  tlb_lookup_clock_replace_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int active_entries();
    int n;
    n = shadow_limit;
    if (n < 1) n = 1;
    if (n > tlbclk_pkg::TLB_DEPTH) n = tlbclk_pkg::TLB_DEPTH;
    return n;
  endfunction

  function automatic tlbclk_pkg::res_t tlb_translate(tlbclk_pkg::req_t r);
    tlbclk_pkg::res_t res;
    int               n;
    int               slot;
    bit               found;
    n = active_entries();
    for (int k = 0; k < n; k++) begin
      if (shadow_valid[k] && shadow_page[k] == r.vpn && shadow_owner[k] == r.process_id) begin
        res.hit = 1'b1;
        res.frame = shadow_frame[k];
        res.mark_page_dirty = 1'b0;
        return res;
      end
    end
    found = 1'b0;
    slot = 0;
    for (int k = 0; k < n && !found; k++) begin
      if (!shadow_valid[k]) begin
        slot = k;
        found = 1'b1;
      end
    end
    if (!found) begin
      slot = shadow_hand;
      while (!found) begin
        slot++;
        if (slot >= n) slot = 0;
        if (!shadow_used[slot]) found = 1'b1;
        else shadow_used[slot] = 1'b0;
      end
    end
    shadow_hand = slot;
    shadow_valid[slot] = 1'b1;
    shadow_used[slot] = 1'b1;
    shadow_page[slot] = r.vpn;
    shadow_frame[slot] = r.table_pfn;
    shadow_owner[slot] = r.process_id;
    res.hit = 1'b0;
    res.frame = r.table_pfn;
    res.mark_page_dirty = r.is_write;
    return res;
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // mostly revisits recent page/owner pairs so hits and sweeps both happen
  function automatic tlbclk_pkg::req_t make_req();
    tlbclk_pkg::req_t r;
    int               pick;
    int               win;
    int               idx;
    r.vpn = tlbclk_pkg::VPN_BITS'($urandom);
    r.process_id = tlbclk_pkg::PID_BITS'($urandom);
    r.is_write = 1'($urandom);
    r.table_pfn = tlbclk_pkg::PFN_BITS'($urandom);
    pick = $urandom_range(0, 99);
    win = active_entries() + 4;
    if (win > recent_pairs.size()) win = recent_pairs.size();
    if (win > 0) begin
      idx = recent_pairs.size() - 1 - $urandom_range(0, win - 1);
      if (pick < 65) begin
        r.vpn = recent_pairs[idx].vpn;
        r.process_id = recent_pairs[idx].process_id;
      end else if (pick < 73) begin
        r.vpn = recent_pairs[idx].vpn;
      end else if (pick < 78) begin
        r.process_id = recent_pairs[idx].process_id;
      end else if (pick < 82) begin
        r.vpn = ($urandom_range(0, 1) == 0) ? '0 : VPN_TOP;
      end
    end
    recent_pairs.push_back(r);
    if (recent_pairs.size() > 24) void'(recent_pairs.pop_front());
    return r;
  endfunction

  task automatic send_req(input tlbclk_pkg::req_t r, input bit calm, input bit typed,
                          input tlbclk_pkg::res_t want);
    int               gap;
    tlbclk_pkg::res_t predicted;
    gap = calm ? 0 : stall_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= tlbclk_pkg::IN_TDATA_W'(r);
    do @(posedge clk); while (!in_tready);
    predicted = tlb_translate(r);
    xlat_pending.push_back(typed ? want : predicted);
  endtask

  task automatic write_limit(input logic [tlbclk_pkg::CFG_W-1:0] value);
    in_tvalid <= 1'b0;
    while (xlat_pending.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow_limit = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic add_xlat(input logic [tlbclk_pkg::VPN_BITS-1:0] vpn, input logic wr,
                          input logic [tlbclk_pkg::PID_BITS-1:0] pid,
                          input logic [tlbclk_pkg::PFN_BITS-1:0] pfn,
                          input bit typed, input logic hit,
                          input logic [tlbclk_pkg::PFN_BITS-1:0] frame,
                          input logic mark);
    dir_row_t row;
    row.kind = ROW_XLAT;
    row.req.vpn = vpn;
    row.req.is_write = wr;
    row.req.process_id = pid;
    row.req.table_pfn = pfn;
    row.limit = '0;
    row.typed = typed;
    row.want.hit = hit;
    row.want.frame = frame;
    row.want.mark_page_dirty = mark;
    dir_rows.push_back(row);
  endtask

  task automatic add_limit(input logic [tlbclk_pkg::CFG_W-1:0] value);
    dir_row_t row;
    row.kind = ROW_LIMIT;
    row.req = '0;
    row.limit = value;
    row.typed = 1'b0;
    row.want = '0;
    dir_rows.push_back(row);
  endtask

  initial begin
    logic [tlbclk_pkg::CFG_W-1:0] phase_limits [9];
    tlbclk_pkg::res_t             none;
    for (int k = 0; k < tlbclk_pkg::TLB_DEPTH; k++) begin
      shadow_valid[k] = 1'b0;
      shadow_used[k] = 1'b0;
      shadow_page[k] = '0;
      shadow_frame[k] = '0;
      shadow_owner[k] = '0;
    end
    shadow_hand = 0;
    shadow_limit = tlbclk_pkg::CFG_RESET;
    none = '0;

    // empty buffer, extremes, owner mismatch, write hit
    add_xlat('0, 1'b0, '0, '0, 1, 1'b0, '0, 1'b0);
    add_xlat(VPN_TOP, 1'b1, PID_TOP, PFN_TOP, 1, 1'b0, PFN_TOP, 1'b1);
    add_xlat(VPN_TOP, 1'b1, PID_TOP, '0, 1, 1'b1, PFN_TOP, 1'b0);
    add_xlat(VPN_TOP, 1'b0, '0, 20'h5a5a5, 1, 1'b0, 20'h5a5a5, 1'b0);
    add_xlat('0, 1'b0, PID_TOP, 20'ha5a5a, 1, 1'b0, 20'ha5a5a, 1'b0);
    add_xlat('0, 1'b0, '0, 20'h12345, 1, 1'b1, '0, 1'b0);
    // two entries: hand past the limit, full sweep, entries beyond kept
    add_limit(tlbclk_pkg::CFG_W'(2));
    add_xlat(20'h12345, 1'b1, 8'h07, 20'h0f0f0, 1, 1'b0, 20'h0f0f0, 1'b1);
    add_xlat(VPN_TOP, 1'b0, PID_TOP, '0, 1, 1'b1, PFN_TOP, 1'b0);
    add_xlat(VPN_TOP, 1'b0, '0, 20'h33333, 1, 1'b0, 20'h33333, 1'b0);
    // zero treated as one entry
    add_limit('0);
    add_xlat(20'h12345, 1'b0, 8'h07, 20'h00001, 0, 1'b0, '0, 1'b0);
    add_xlat(20'h00001, 1'b1, 8'h01, 20'h00002, 0, 1'b0, '0, 1'b0);
    // above the depth saturates
    add_limit(tlbclk_pkg::CFG_W'(31));
    add_xlat('0, 1'b0, PID_TOP, 20'h11111, 0, 1'b0, '0, 1'b0);
    add_xlat(VPN_TOP, 1'b1, PID_TOP, 20'h22222, 0, 1'b0, '0, 1'b0);
    add_limit(tlbclk_pkg::CFG_W'(16));

    phase_limits = '{tlbclk_pkg::CFG_W'(1), tlbclk_pkg::CFG_W'(17), tlbclk_pkg::CFG_W'(4),
                     tlbclk_pkg::CFG_W'(16), tlbclk_pkg::CFG_W'(0), tlbclk_pkg::CFG_W'(31),
                     tlbclk_pkg::CFG_W'($urandom_range(0, 31)),
                     tlbclk_pkg::CFG_W'($urandom_range(1, 16)), tlbclk_pkg::CFG_W'(8)};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_LIMIT) write_limit(dir_rows[i].limit);
      else send_req(dir_rows[i].req, 1'b0, dir_rows[i].typed, dir_rows[i].want);
    end

    foreach (phase_limits[p]) begin
      write_limit(phase_limits[p]);
      recent_pairs.delete();
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_req(make_req(), (p % 2 == 0) && (i < 20), 1'b0, none);
    end

    in_tvalid <= 1'b0;
    while (xlat_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += xlat_pending.size();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    int burst;
    @(posedge clk);
    forever begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      out_tready <= 1'b1;
      repeat (burst) @(posedge clk);
      burst = stall_len();
      if (burst > 0) begin
        out_tready <= 1'b0;
        repeat (burst) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    tlbclk_pkg::res_t got;
    tlbclk_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[tlbclk_pkg::OUT_W-1:0];
      if (xlat_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected transaction: hit=%0b frame=%05h dirty=%0b",
                   got.hit, got.frame, got.mark_page_dirty);
      end else begin
        want = xlat_pending.pop_front();
        if (got.hit !== want.hit || got.frame !== want.frame ||
            got.mark_page_dirty !== want.mark_page_dirty) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display({"mismatch: expected hit=%0b frame=%05h dirty=%0b, ",
                      "got hit=%0b frame=%05h dirty=%0b"},
                     want.hit, want.frame, want.mark_page_dirty,
                     got.hit, got.frame, got.mark_page_dirty);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
